FILE: src/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg - crank tooth rpm meter shared definitions
// Widths, register indexes, reset values, event codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

	localparam int TIME_W  = 32;
	localparam int TEETH_W = 6;
	localparam int DEB_W   = 16;
	localparam int RPM_W   = 26;
	localparam int EV_W    = 3;
	localparam int IDX_W   = 3;

	// 60,000,000 fits in RPM_W bits; the divider shifts out one bit per step
	localparam logic [RPM_W-1:0] RPM_NUMERATOR = RPM_W'(60000000);
	localparam int DIV_STEPS = RPM_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [TEETH_W-1:0] TEETH_RST   = TEETH_W'(11);
	localparam logic [DEB_W-1:0]   DEB_RST     = DEB_W'(200);
	localparam logic [TIME_W-1:0]  TIMEOUT_RST = TIME_W'(1000000);
	localparam logic [TIME_W-1:0]  MIN_PER_RST = TIME_W'(6000);
	localparam logic [TIME_W-1:0]  MAX_PER_RST = TIME_W'(200000);

	typedef enum logic [IDX_W-1:0] {
		REG_TEETH   = 3'd0,
		REG_DEB     = 3'd1,
		REG_TIMEOUT = 3'd2,
		REG_MIN_PER = 3'd3,
		REG_MAX_PER = 3'd4
	} reg_idx_t;

	typedef enum logic [EV_W-1:0] {
		EV_STALL    = 3'd0,
		EV_BOUNCE   = 3'd1,
		EV_TOOTH    = 3'd2,
		EV_UPDATED  = 3'd3,
		EV_REJECTED = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_STALL,
		ST_BOUNCE,
		ST_PERIOD,
		ST_MIN,
		ST_MAX,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: src/crank_tooth_rpm_meter_core.sv
// ----------------------------------------------------------------------------
// crank_tooth_rpm_meter_core - engine speed from crank tooth edge timestamps
// One shared 33-bit subtractor under a small sequencer does the gap, window
// and period math and a restoring divide of 60,000,000 by the period.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   : in_valid/in_ready, edge_time_us = microsecond stamp of one
//                  falling crank edge. in_ready is high only while idle.
//   out channel  : out_valid/out_ready, one word per edge: rpm and event_res
//                  (stall, bounce, tooth, rpm updated, period rejected).
//   cfg channel  : cfg_valid/cfg_ready, cfg_index selects the register,
//                  cfg_data holds the value; always ready, write when idle.
// Path from accept to out_valid: a stall runs GAP, STALL and FIN; a bounce
//   or plain tooth adds BOUNCE; a rejected period adds PERIOD, MIN and maybe
//   MAX; an rpm update adds MAX and DIV. in_ready is back in the cycle after
//   FIN loads the word. The 26 divide steps on the shared subtractor set the
//   worst case; one edge is in work at a time.
// The result sits in an output register, so the next edge is taken while a
//   word waits; if the receiver still stalls when the next edge finishes,
//   the sequencer holds in its last state until the register frees.
// Reset: registers return to their defaults, tooth count, edge and
//   revolution times and rpm are zero, out_valid drops.
// ----------------------------------------------------------------------------
`default_nettype none

module crank_tooth_rpm_meter_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [crm_pkg::TIME_W-1:0]   edge_time_us,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [crm_pkg::RPM_W-1:0]    rpm,
	output logic      [crm_pkg::EV_W-1:0]     event_res,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [crm_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [crm_pkg::TIME_W-1:0]   cfg_data
);
	import crm_pkg::*;

	// config registers
	logic [TEETH_W-1:0] teeth_q;
	logic [DEB_W-1:0]   deb_q;
	logic [TIME_W-1:0]  timeout_q, min_per_q, max_per_q;

	// block state
	state_t             state_q, state_d;
	logic [TIME_W-1:0]  last_edge_q, last_edge_d;
	logic [TIME_W-1:0]  last_rev_q, last_rev_d;
	logic [TEETH_W-1:0] tooth_q, tooth_d;
	logic [RPM_W-1:0]   rpm_val_q, rpm_val_d;

	// work registers
	logic [TIME_W-1:0]  now_q, now_d;
	logic [TIME_W-1:0]  gap_q, gap_d;
	logic [TIME_W-1:0]  per_q, per_d;
	logic [TIME_W-1:0]  rem_q, rem_d;
	logic [RPM_W-1:0]   nq_q, nq_d;
	logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
	event_t             ev_q, ev_d;

	// output register
	logic               out_valid_q, out_valid_d;
	logic [RPM_W-1:0]   out_rpm_q, out_rpm_d;
	event_t             out_ev_q, out_ev_d;

	// shared subtractor
	logic [TIME_W:0]    sub_a, sub_b;
	logic [TIME_W+1:0]  sub_r;
	logic               borrow;
	logic [TEETH_W-1:0] tooth_inc;
	logic               in_acc;

	assign sub_r     = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow    = sub_r[TIME_W+1];
	assign tooth_inc = tooth_q + TEETH_W'(1);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign rpm       = out_rpm_q;
	assign event_res = out_ev_q;

	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			ST_GAP: begin
				sub_a = {1'b0, now_q};
				sub_b = {1'b0, last_edge_q};
			end
			ST_STALL: begin  // borrow: gap above timeout
				sub_a = {1'b0, timeout_q};
				sub_b = {1'b0, gap_q};
			end
			ST_BOUNCE: begin // borrow: gap below debounce
				sub_a = {1'b0, gap_q};
				sub_b = {{(TIME_W+1-DEB_W){1'b0}}, deb_q};
			end
			ST_PERIOD: begin
				sub_a = {1'b0, now_q};
				sub_b = {1'b0, last_rev_q};
			end
			ST_MIN: begin    // borrow: period above min
				sub_a = {1'b0, min_per_q};
				sub_b = {1'b0, per_q};
			end
			ST_MAX: begin    // borrow: period below max
				sub_a = {1'b0, per_q};
				sub_b = {1'b0, max_per_q};
			end
			ST_DIV: begin    // trial subtract of shifted remainder
				sub_a = {rem_q, nq_q[RPM_W-1]};
				sub_b = {1'b0, per_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		last_edge_d = last_edge_q;
		last_rev_d  = last_rev_q;
		tooth_d     = tooth_q;
		rpm_val_d   = rpm_val_q;
		now_d       = now_q;
		gap_d       = gap_q;
		per_d       = per_q;
		rem_d       = rem_q;
		nq_d        = nq_q;
		dcnt_d      = dcnt_q;
		ev_d        = ev_q;
		out_valid_d = out_valid_q;
		out_rpm_d   = out_rpm_q;
		out_ev_d    = out_ev_q;

		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					now_d   = edge_time_us;
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				gap_d   = sub_r[TIME_W-1:0];
				state_d = ST_STALL;
			end
			ST_STALL: begin
				if (borrow) begin
					rpm_val_d   = '0;
					tooth_d     = '0;
					last_edge_d = now_q;
					last_rev_d  = now_q;
					ev_d        = EV_STALL;
					state_d     = ST_FIN;
				end else begin
					state_d = ST_BOUNCE;
				end
			end
			ST_BOUNCE: begin
				if (borrow) begin
					ev_d    = EV_BOUNCE;
					state_d = ST_FIN;
				end else begin
					last_edge_d = now_q;
					if (tooth_inc >= teeth_q) begin
						tooth_d = '0;
						state_d = ST_PERIOD;
					end else begin
						tooth_d = tooth_inc;
						ev_d    = EV_TOOTH;
						state_d = ST_FIN;
					end
				end
			end
			ST_PERIOD: begin
				per_d      = sub_r[TIME_W-1:0];
				last_rev_d = now_q;
				state_d    = ST_MIN;
			end
			ST_MIN: begin
				if (borrow) begin
					state_d = ST_MAX;
				end else begin
					ev_d    = EV_REJECTED;
					state_d = ST_FIN;
				end
			end
			ST_MAX: begin
				if (borrow) begin
					rem_d   = '0;
					nq_d    = RPM_NUMERATOR;
					dcnt_d  = '0;
					state_d = ST_DIV;
				end else begin
					ev_d    = EV_REJECTED;
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				// quotient bits shift in behind the numerator bits
				if (borrow)
					rem_d = sub_a[TIME_W-1:0];
				else
					rem_d = sub_r[TIME_W-1:0];
				nq_d   = {nq_q[RPM_W-2:0], ~borrow};
				dcnt_d = dcnt_q + DCNT_W'(1);
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					rpm_val_d = {nq_q[RPM_W-2:0], ~borrow};
					ev_d      = EV_UPDATED;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_rpm_d   = rpm_val_q;
					out_ev_d    = ev_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_edge_q <= '0;
			last_rev_q  <= '0;
			tooth_q     <= '0;
			rpm_val_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			last_edge_q <= last_edge_d;
			last_rev_q  <= last_rev_d;
			tooth_q     <= tooth_d;
			rpm_val_q   <= rpm_val_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		now_q     <= now_d;
		gap_q     <= gap_d;
		per_q     <= per_d;
		rem_q     <= rem_d;
		nq_q      <= nq_d;
		dcnt_q    <= dcnt_d;
		ev_q      <= ev_d;
		out_rpm_q <= out_rpm_d;
		out_ev_q  <= out_ev_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			teeth_q   <= TEETH_RST;
			deb_q     <= DEB_RST;
			timeout_q <= TIMEOUT_RST;
			min_per_q <= MIN_PER_RST;
			max_per_q <= MAX_PER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEETH:   teeth_q   <= cfg_data[TEETH_W-1:0];
				REG_DEB:     deb_q     <= cfg_data[DEB_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MIN_PER: min_per_q <= cfg_data;
				REG_MAX_PER: max_per_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisor is never zero and the remainder stays below it while dividing
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> per_q != '0)
		else $error("divide started with zero period");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < per_q)
		else $error("divider remainder out of range");

	a_rpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		{6'd0, rpm_val_q} <= {6'd0, RPM_NUMERATOR})
		else $error("rpm above numerator");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_GAP)
		else $error("accepted word did not start the sequencer");

	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ev_q == EV_STALL |-> out_rpm_q == '0)
		else $error("stall word with nonzero rpm");

endmodule

`default_nettype wire

FILE: dv/tb_crank_tooth_rpm_meter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crank_tooth_rpm_meter_core - self-checking bench for the crank rpm meter
// Streams tooth edge timestamps through the core under random handshake gaps,
// predicts rpm and event per edge in the bench and compares every output word.
// ----------------------------------------------------------------------------

module tb_crank_tooth_rpm_meter_core;

	import crm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYC  = 40;
	localparam logic [IDX_W-1:0] UNMAPPED_LO = 3'd5;
	localparam logic [IDX_W-1:0] UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		event_t           ev;
	} rpm_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TIME_W-1:0] edge_time_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [RPM_W-1:0] rpm;
	logic [EV_W-1:0] event_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0] cfg_data = '0;

	// predicted core state and register copy
	logic [TIME_W-1:0]  p_last_edge = '0;
	logic [TEETH_W-1:0] p_teeth = '0;
	logic [TIME_W-1:0]  p_rev_start = '0;
	logic [RPM_W-1:0]   p_rpm = '0;
	logic [TEETH_W-1:0] c_teeth = TEETH_RST;
	logic [DEB_W-1:0]   c_deb = DEB_RST;
	logic [TIME_W-1:0]  c_timeout = TIMEOUT_RST;
	logic [TIME_W-1:0]  c_min = MIN_PER_RST;
	logic [TIME_W-1:0]  c_max = MAX_PER_RST;

	logic [TIME_W-1:0] stamp_q[$];
	rpm_word_t speed_q[$];
	logic [TIME_W-1:0] gen_last = '0;

	logic in_taken = 1'b0;
	int in_wait = 0;
	int out_hold = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;
	int unsigned err_cnt = 0;
	int unsigned cycles = 0;

	crank_tooth_rpm_meter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.edge_time_us (edge_time_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rpm          (rpm),
		.event_res    (event_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rpm_word_t crank_predict(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] gap;
		logic [TIME_W-1:0] period;
		rpm_word_t w;
		gap = now - p_last_edge;
		if (gap > c_timeout) begin
			p_rpm = '0;
			p_teeth = '0;
			p_last_edge = now;
			p_rev_start = now;
			w.ev = EV_STALL;
		end else if (gap < TIME_W'(c_deb)) begin
			w.ev = EV_BOUNCE;
		end else begin
			p_last_edge = now;
			p_teeth = p_teeth + 1'b1;
			w.ev = EV_TOOTH;
			if (p_teeth >= c_teeth) begin
				period = now - p_rev_start;
				p_rev_start = now;
				p_teeth = '0;
				if (period > c_min && period < c_max) begin
					p_rpm = RPM_W'(TIME_W'(RPM_NUMERATOR) / period);
					w.ev = EV_UPDATED;
				end else begin
					w.ev = EV_REJECTED;
				end
			end
		end
		w.rpm = p_rpm;
		return w;
	endfunction

	function automatic void set_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
		case (idx)
			REG_TEETH:   c_teeth = data[TEETH_W-1:0];
			REG_DEB:     c_deb = data[DEB_W-1:0];
			REG_TIMEOUT: c_timeout = data;
			REG_MIN_PER: c_min = data;
			REG_MAX_PER: c_max = data;
			default: ;
		endcase
	endfunction

	// mostly short gaps, a few long ones; quiet stretches return no gap at all
	function automatic int idle_len(inout bit quiet);
		int r;
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// called at a falling edge; returns at the falling edge after the write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
	endtask

	task automatic push_gap(input logic [TIME_W-1:0] g);
		gen_last = gen_last + g;
		stamp_q.push_back(gen_last);
	endtask

	// edge that does not advance the generated-edge reference (meant as a bounce)
	task automatic push_off(input logic [TIME_W-1:0] off);
		stamp_q.push_back(gen_last + off);
	endtask

	task automatic drain();
		while (stamp_q.size() != 0 || in_valid || speed_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// hold word until accepted
		end else if (in_wait > 0) begin
			in_wait--;
			in_valid <= 1'b0;
		end else if (stamp_q.size() != 0) begin
			in_valid <= 1'b1;
			edge_time_us <= stamp_q.pop_front();
			in_wait = idle_len(quiet_in);
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				out_hold = idle_len(quiet_out);
		end
	end

	always @(posedge clk) begin
		rpm_word_t w;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				speed_q.push_back(crank_predict(edge_time_us));
			if (out_valid && out_ready) begin
				if (speed_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("ERROR: unexpected word rpm=%0d event=%0d", rpm, event_res);
				end else begin
					w = speed_q.pop_front();
					if (rpm !== w.rpm || event_res !== w.ev) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("ERROR: rpm exp %0d got %0d, event exp %0d got %0d",
								w.rpm, rpm, w.ev, event_res);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned r, k, ph, i, teeth_sel, eff, deb, tg, nom, tmo, wmin, wmax;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: first edge against time zero (bounce), tooth, bounce, stall
		push_off(0);
		push_gap(200);
		push_off(199);
		push_gap(1000001);
		drain();

		// one tooth per rev, open window: fastest rpm, zero period, huge periods
		write_reg(REG_TEETH, 32'h0000_0041);
		write_reg(REG_DEB, 32'h0001_0000);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_MIN_PER, 32'h0);
		write_reg(REG_MAX_PER, 32'hFFFF_FFFF);
		write_reg(UNMAPPED_LO, $urandom());
		write_reg(UNMAPPED_HI, $urandom());
		cfg_valid <= 1'b0;
		push_gap(1);
		push_gap(0);
		push_gap(32'hFFFF_FFFE);
		push_gap(32'hFFFF_FFFF);
		drain();

		// zero timeout: any nonzero gap stalls
		write_reg(REG_TIMEOUT, 32'h0);
		cfg_valid <= 1'b0;
		push_gap(0);
		push_gap(1);
		drain();

		// window and limit boundaries
		write_reg(REG_DEB, 32'd10);
		write_reg(REG_TIMEOUT, 32'd1000);
		write_reg(REG_MIN_PER, 32'd100);
		write_reg(REG_MAX_PER, 32'd200);
		cfg_valid <= 1'b0;
		push_gap(100);
		push_gap(101);
		push_gap(199);
		push_gap(200);
		push_off(9);
		push_gap(10);
		push_gap(1000);
		push_gap(1001);
		drain();

		// count left above a lowered teeth setting, then zero teeth
		write_reg(REG_TEETH, 32'd5);
		write_reg(REG_DEB, 32'd0);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_MIN_PER, 32'h0);
		write_reg(REG_MAX_PER, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		repeat (3) push_gap(50);
		drain();
		write_reg(REG_TEETH, 32'd2);
		cfg_valid <= 1'b0;
		push_gap(50);
		drain();
		write_reg(REG_TEETH, 32'd64);
		cfg_valid <= 1'b0;
		push_gap(7);
		push_gap(3);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			r = $urandom_range(0, 9);
			teeth_sel = (r == 0) ? 0 : (r == 1) ? 63 : (r == 2) ? 1 : $urandom_range(2, 12);
			eff = (teeth_sel == 0) ? 1 : teeth_sel;
			r = $urandom_range(0, 9);
			deb = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 1000);
			tg = deb + deb / 2 + 16 + $urandom_range(0, 4000);
			nom = tg * eff;
			r = $urandom_range(0, 9);
			case (r)
				0: begin
					wmin = 0;
					wmax = 32'hFFFF_FFFF;
				end
				1: begin
					// inverted window
					wmin = nom + $urandom_range(0, nom / 8);
					wmax = nom - $urandom_range(0, nom / 8);
				end
				2: begin
					wmin = 32'hFFFF_FFFF;
					wmax = $urandom();
				end
				default: begin
					wmin = nom - $urandom_range(0, nom / 6);
					wmax = nom + $urandom_range(1, nom / 6 + 1);
				end
			endcase
			r = $urandom_range(0, 9);
			tmo = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? $urandom_range(1, tg) :
				tg * 3 + $urandom_range(0, tg * 4);

			// junk in the unused upper bits of the narrow registers
			write_reg(REG_TEETH, ($urandom() & 32'hFFFF_FFC0) | teeth_sel);
			write_reg(REG_DEB, ($urandom() & 32'hFFFF_0000) | deb);
			write_reg(REG_TIMEOUT, tmo);
			write_reg(REG_MIN_PER, wmin);
			write_reg(REG_MAX_PER, wmax);
			cfg_valid <= 1'b0;

			if (ph == 3)
				gen_last = 32'hFFFF_FFFF - $urandom_range(0, 200000);

			for (i = 0; i < 85; i++) begin
				r = $urandom_range(0, 99);
				if (r < 72) begin
					push_gap(tg - tg / 4 + $urandom_range(0, tg / 2));
				end else if (r < 82) begin
					push_off($urandom_range(0, deb));
				end else if (r < 88) begin
					push_gap((tmo > 32'hF000_0000) ? $urandom() : tmo + 1 + $urandom_range(0, tg));
				end else if (r < 94) begin
					k = $urandom_range(0, 3);
					case (k)
						0: push_gap(deb);
						1: push_off((deb == 0) ? 0 : deb - 1);
						2: push_gap(tmo);
						default: push_gap(tmo + 1);
					endcase
				end else begin
					gen_last = $urandom();
					stamp_q.push_back(gen_last);
				end
			end
			drain();
		end

		if (err_cnt == 0 && speed_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
